FILE: rtl/dense_layer_net_input_core_macros.svh
// ----------------------------------------------------------------------------
// dense layer net input core assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_NET_INPUT_CORE_MACROS_SVH
`define DENSE_LAYER_NET_INPUT_CORE_MACROS_SVH

// same-cycle implication
`define DLNI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dlni port check failed");

// next-cycle implication
`define DLNI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dlni port check failed");

`endif

FILE: rtl/dlni_pkg.sv
// ----------------------------------------------------------------------------
// dlni_pkg
// shared constants, codes and control types of the dense layer net input core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlni_pkg;

   localparam int MAX_ROWS  = 64;
   localparam int MAX_COLS  = 64;
   localparam int COL_REACH = 64;
   localparam int COL_LIMIT = (MAX_COLS < COL_REACH) ? MAX_COLS : COL_REACH;

   localparam int ROW_AW  = $clog2(MAX_ROWS);
   localparam int COL_AW  = $clog2(MAX_COLS);
   localparam int W_AW    = ROW_AW + COL_AW;
   localparam int CNT_W   = 7;
   localparam int VAL_W   = 16;
   localparam int BIAS_W  = 32;
   localparam int PROD_W  = 32;
   localparam int ACC_W   = 48;
   localparam int NET_W   = 32;
   localparam int REQ_RW  = 6;
   localparam int REQ_CW  = 6;

   localparam logic CSR_ROW_COUNT    = 1'b0;
   localparam logic CSR_COLUMN_COUNT = 1'b1;

   typedef enum logic [1:0] {
      MODE_WEIGHT = 2'd0,
      MODE_BIAS   = 2'd1,
      MODE_SOURCE = 2'd2,
      MODE_START  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic              load;
      logic              issue;
      logic [ROW_AW-1:0] row;
      logic [COL_AW-1:0] col;
      logic              first;
      logic              last_col;
      logic              last_row;
   } dlni_cmd_type;

   typedef struct packed {
      logic rsp_done;
   } dlni_sts_type;

   typedef struct packed {
      logic              valid;
      logic              first;
      logic              last_col;
      logic              last_row;
      logic [ROW_AW-1:0] row;
   } dlni_tag_type;

endpackage

FILE: rtl/dlni_dp.sv
// ----------------------------------------------------------------------------
// dlni_dp
// weight, bias and source stores, multiply-accumulate pipe and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlni_dp
   import dlni_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_mode,
   input  logic [REQ_RW-1:0]        req_row,
   input  logic [REQ_CW-1:0]        req_col,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic signed [BIAS_W-1:0] req_bias_value,
   input  dlni_cmd_type             cmd,
   output dlni_sts_type             sts,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [REQ_RW-1:0]        rsp_row_index,
   output logic signed [NET_W-1:0]  rsp_net_value,
   output logic                     rsp_last
);

   logic [VAL_W-1:0]  weight_mem [MAX_ROWS*MAX_COLS];
   logic [BIAS_W-1:0] bias_mem   [MAX_ROWS];
   logic [VAL_W-1:0]  source_mem [MAX_COLS];

   logic              row_ok;
   logic              col_ok;
   logic [W_AW-1:0]   wr_waddr;
   logic [W_AW-1:0]   rd_waddr;

   logic signed [VAL_W-1:0]  w_rd_ff;
   logic signed [VAL_W-1:0]  s_rd_ff;
   logic signed [BIAS_W-1:0] b_rd_ff;
   dlni_tag_type             t1_ff;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [BIAS_W-1:0] b2_ff;
   dlni_tag_type             t2_ff;

   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [BIAS_W-1:0] b3_ff;
   dlni_tag_type             t3_ff, t3_in;

   logic signed [ACC_W-1:0]  total;
   logic signed [NET_W-1:0]  sat;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [REQ_RW-1:0]        rsp_row_ff;
   logic signed [NET_W-1:0]  rsp_net_ff;
   logic                     rsp_last_ff;
   logic                     fire;

   assign row_ok   = ({1'b0, req_row} < (REQ_RW+1)'(MAX_ROWS));
   assign col_ok   = ({1'b0, req_col} < (REQ_CW+1)'(MAX_COLS));
   assign wr_waddr = {req_row[ROW_AW-1:0], req_col[COL_AW-1:0]};
   assign rd_waddr = {cmd.row, cmd.col};

   // store writes
   always_ff @(posedge clock) begin
      if (cmd.load && req_mode == MODE_WEIGHT && row_ok && col_ok) begin
         weight_mem[wr_waddr] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_mode == MODE_BIAS && row_ok) begin
         bias_mem[req_row[ROW_AW-1:0]] <= req_bias_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_mode == MODE_SOURCE && col_ok) begin
         source_mem[req_col[COL_AW-1:0]] <= req_value;
      end
   end

   // registered store reads
   always_ff @(posedge clock) begin
      w_rd_ff <= weight_mem[rd_waddr];
   end

   always_ff @(posedge clock) begin
      s_rd_ff <= source_mem[cmd.col];
   end

   always_ff @(posedge clock) begin
      b_rd_ff <= bias_mem[cmd.row];
   end

   // multiply and accumulate
   assign prod_in = w_rd_ff * s_rd_ff;

   always_comb begin
      acc_in = acc_ff;
      if (t2_ff.valid) begin
         acc_in = (t2_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      t3_in       = t2_ff;
      t3_in.valid = t2_ff.valid && t2_ff.last_col;
   end

   // bias add and saturation
   assign total = acc_ff + ACC_W'(b3_ff);

   always_comb begin
      if (total > ACC_W'(64'sh7FFF_FFFF)) begin
         sat = {1'b0, {(NET_W-1){1'b1}}};
      end else if (total < -ACC_W'(64'sh8000_0000)) begin
         sat = {1'b1, {(NET_W-1){1'b0}}};
      end else begin
         sat = total[NET_W-1:0];
      end
   end

   assign fire = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (t3_ff.valid) begin
         rsp_valid_in = 1'b1;
      end else if (fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff        <= '0;
         t2_ff        <= '0;
         t3_ff        <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         t1_ff.valid    <= cmd.issue;
         t1_ff.first    <= cmd.first;
         t1_ff.last_col <= cmd.last_col;
         t1_ff.last_row <= cmd.last_row;
         t1_ff.row      <= cmd.row;
         t2_ff          <= t1_ff;
         t3_ff          <= t3_in;
         acc_ff         <= acc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      b2_ff   <= b_rd_ff;
      b3_ff   <= b2_ff;
      if (t3_ff.valid) begin
         rsp_row_ff  <= REQ_RW'(t3_ff.row);
         rsp_net_ff  <= sat;
         rsp_last_ff <= t3_ff.last_row;
      end
   end

   assign sts.rsp_done  = fire;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_row_index = rsp_row_ff;
   assign rsp_net_value = rsp_net_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: rtl/dlni_ctrl.sv
// ----------------------------------------------------------------------------
// dlni_ctrl
// count registers and the row and column sequencer of the net input core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlni_ctrl
   import dlni_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_mode,
   output logic             req_stall,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CNT_W-1:0] csr_data,
   input  dlni_sts_type     sts,
   output dlni_cmd_type     cmd
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  row_count_ff, row_count_in;
   logic [CNT_W-1:0]  column_count_ff, column_count_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic [COL_AW-1:0] col_ff, col_in;
   logic [ROW_AW-1:0] last_row_ff, last_row_in;
   logic [COL_AW-1:0] last_col_ff, last_col_in;
   logic [ROW_AW-1:0] rows_m1;
   logic [COL_AW-1:0] cols_m1;
   logic              start;
   logic              at_last_col;
   logic              at_last_row;

   assign csr_ready   = 1'b1;
   assign start       = req_valid && req_mode == MODE_START;
   assign at_last_col = (col_ff == last_col_ff);
   assign at_last_row = (row_ff == last_row_ff);

   // count registers, zero acts as one, large values clip
   always_comb begin
      if (row_count_ff == '0) begin
         rows_m1 = '0;
      end else if (row_count_ff > CNT_W'(MAX_ROWS)) begin
         rows_m1 = ROW_AW'(MAX_ROWS - 1);
      end else begin
         rows_m1 = ROW_AW'(row_count_ff - CNT_W'(1));
      end
      if (column_count_ff == '0) begin
         cols_m1 = '0;
      end else if (column_count_ff > CNT_W'(COL_LIMIT)) begin
         cols_m1 = COL_AW'(COL_LIMIT - 1);
      end else begin
         cols_m1 = COL_AW'(column_count_ff - CNT_W'(1));
      end
   end

   always_comb begin
      row_count_in    = row_count_ff;
      column_count_in = column_count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_COUNT:    row_count_in    = csr_data;
            CSR_COLUMN_COUNT: column_count_in = csr_data;
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (at_last_col) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (sts.rsp_done) begin
               state_in = at_last_row ? ST_IDLE : ST_ISSUE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // loop counters
   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      last_row_in = last_row_ff;
      last_col_in = last_col_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               row_in      = '0;
               col_in      = '0;
               last_row_in = rows_m1;
               last_col_in = cols_m1;
            end
         end
         ST_ISSUE: col_in = col_ff + COL_AW'(1);
         ST_WAIT: begin
            if (sts.rsp_done) begin
               row_in = row_ff + ROW_AW'(1);
               col_in = '0;
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_stall    = (state_ff != ST_IDLE);
      cmd.load     = req_valid && (state_ff == ST_IDLE);
      cmd.issue    = (state_ff == ST_ISSUE);
      cmd.row      = row_ff;
      cmd.col      = col_ff;
      cmd.first    = (col_ff == '0);
      cmd.last_col = at_last_col;
      cmd.last_row = at_last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         row_count_ff    <= CNT_W'(MAX_ROWS);
         column_count_ff <= CNT_W'(COL_LIMIT);
         row_ff          <= '0;
         col_ff          <= '0;
         last_row_ff     <= '0;
         last_col_ff     <= '0;
      end else begin
         state_ff        <= state_in;
         row_count_ff    <= row_count_in;
         column_count_ff <= column_count_in;
         row_ff          <= row_in;
         col_ff          <= col_in;
         last_row_ff     <= last_row_in;
         last_col_ff     <= last_col_in;
      end
   end

endmodule

FILE: rtl/dense_layer_net_input_core.sv
// ----------------------------------------------------------------------------
// dense_layer_net_input_core
// fully connected layer net input: weight matrix times source vector plus bias
//
//   channel  direction  handshake            beat
//   req      in         req_valid/req_stall  load weight, bias, source or start
//   rsp      out        rsp_valid/rsp_stall  one row: index, net value, last
//   csr      in         csr_valid/csr_ready  row_count or column_count write
//
// a load beat is not held while the core is idle; a start beat holds the input until its
// last row beat is taken, the single multiply-accumulate pipe reading one weight a cycle
// each row waits for its result beat to be taken before the next row begins
// stores are not cleared by reset; counts reset to 64
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dense_layer_net_input_core
   import dlni_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_mode,
   input  logic [REQ_RW-1:0]        req_row,
   input  logic [REQ_CW-1:0]        req_col,
   input  logic signed [VAL_W-1:0]  req_value,
   input  logic signed [BIAS_W-1:0] req_bias_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [REQ_RW-1:0]        rsp_row_index,
   output logic signed [NET_W-1:0]  rsp_net_value,
   output logic                     rsp_last,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  logic [CNT_W-1:0]         csr_data
);

   dlni_cmd_type cmd;
   dlni_sts_type sts;

   dlni_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .sts       (sts),
      .cmd       (cmd)
   );

   dlni_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .req_bias_value (req_bias_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_index  (rsp_row_index),
      .rsp_net_value  (rsp_net_value),
      .rsp_last       (rsp_last)
   );

endmodule

FILE: rtl/dlni_checker.sv
// ----------------------------------------------------------------------------
// dlni_checker
// port-level checks of the dense layer net input core, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dense_layer_net_input_core_macros.svh"

module dlni_checker
   import dlni_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [1:0]               req_mode,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [REQ_RW-1:0]        rsp_row_index,
   input logic signed [NET_W-1:0]  rsp_net_value,
   input logic                     rsp_last
);

   // a pending result keeps loads and starts out
   `DLNI_ASSERT_NOW(a_rsp_blocks_req, rsp_valid, req_stall)

   // a start beat begins a run at once
   `DLNI_ASSERT_NEXT(a_start_busy, req_valid && !req_stall && req_mode == MODE_START, req_stall)

   // the last row ends the run and frees the input
   `DLNI_ASSERT_NEXT(a_last_ends, rsp_valid && !rsp_stall && rsp_last, !rsp_valid && !req_stall)

   // a row taken is never shown twice
   `DLNI_ASSERT_NEXT(a_rsp_once, rsp_valid && !rsp_stall, !rsp_valid)

   // a stalled result holds
   `DLNI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_row_index) && $stable(rsp_net_value) && $stable(rsp_last))

endmodule

bind dense_layer_net_input_core dlni_checker u_checker (.*);

FILE: tb/sv/tb_dense_layer_net_input_core.sv
// ----------------------------------------------------------------------------
// tb_dense_layer_net_input_core
// self-checking bench for the dense layer net input core: loads weights,
// biases and source elements, fires start beats under several row and column
// counts, and checks every row beat against an in-bench fixed-point predictor
// while the sender runs in bursts and the receiver stalls on its own pattern
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dense_layer_net_input_core;
   import dlni_pkg::*;

   localparam int ITEM_TARGET = 460;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 3000000;
   localparam longint NET_HI = 64'sd2147483647;
   localparam longint NET_LO = -64'sd2147483648;

   typedef struct {
      mode_type    mode;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [15:0] value;
      logic [31:0] bias_value;
      bit          drain_first;
   } layer_beat_type;

   typedef struct {
      logic [5:0]         row_index;
      logic signed [31:0] net_value;
      logic               last;
   } net_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_mode = '0;
   logic [REQ_RW-1:0]        req_row = '0;
   logic [REQ_CW-1:0]        req_col = '0;
   logic signed [VAL_W-1:0]  req_value = '0;
   logic signed [BIAS_W-1:0] req_bias_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [REQ_RW-1:0]        rsp_row_index;
   logic signed [NET_W-1:0]  rsp_net_value;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic                     csr_index = 1'b0;
   logic [CNT_W-1:0]         csr_data = '0;

   // predictor state
   logic signed [15:0] weight_mem [0:63][0:63];
   logic signed [31:0] bias_mem [0:63];
   logic signed [15:0] source_mem [0:63];
   logic [6:0]         row_count_reg = 7'd64;
   logic [6:0]         column_count_reg = 7'd64;
   net_result_type     net_expect [$];

   // stimulus side bookkeeping
   bit             weight_set [0:63][0:63];
   bit             bias_set [0:63];
   bit             source_set [0:63];
   int             gen_rows = 64;
   int             gen_cols = 64;
   int             item_total = 0;
   layer_beat_type beat_pending [$];

   logic           req_fire = 1'b0;
   layer_beat_type beat_now;
   net_result_type rsp_want;
   int             burst_left = 8;
   int             gap_left = 0;
   int             stall_style = 0;
   int             cycle_count = 0;
   int             fail_count = 0;

   dense_layer_net_input_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .req_bias_value (req_bias_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_row_index  (rsp_row_index),
      .rsp_net_value  (rsp_net_value),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int clip_count(input logic [6:0] raw, input int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   function automatic void predict_net_rows();
      int     rows;
      int     cols;
      longint acc;
      net_result_type res;
      rows = clip_count(row_count_reg, MAX_ROWS);
      cols = clip_count(column_count_reg, COL_LIMIT);
      for (int r = 0; r < rows; r++) begin
         acc = 0;
         for (int c = 0; c < cols; c++) begin
            acc += longint'(weight_mem[r][c]) * longint'(source_mem[c]);
         end
         acc += longint'(bias_mem[r]);
         if (acc > NET_HI) acc = NET_HI;
         if (acc < NET_LO) acc = NET_LO;
         res.row_index = r[5:0];
         res.net_value = acc[31:0];
         res.last = (r + 1 == rows);
         net_expect.push_back(res);
      end
   endfunction

   function automatic void absorb_beat(input logic [1:0] mode, input logic [5:0] row,
                                       input logic [5:0] col, input logic [15:0] value,
                                       input logic [31:0] bias);
      case (mode)
         MODE_WEIGHT: weight_mem[row][col] = value;
         MODE_BIAS:   bias_mem[row] = bias;
         MODE_SOURCE: source_mem[col] = value;
         default:     predict_net_rows();
      endcase
   endfunction

   function automatic logic [15:0] rand_q88();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(0, 511)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_q1616();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2, 3: return 32'($signed($urandom_range(0, 2097151)) - 1048576);
         default: return $urandom;
      endcase
   endfunction

   function automatic void queue_beat(input mode_type mode, input int row, input int col,
                                      input logic [15:0] value, input logic [31:0] bias,
                                      input bit drain);
      layer_beat_type b;
      b.mode = mode;
      b.row = row[5:0];
      b.col = col[5:0];
      b.value = value;
      b.bias_value = bias;
      b.drain_first = drain;
      beat_pending.push_back(b);
      item_total++;
      case (mode)
         MODE_WEIGHT: weight_set[b.row][b.col] = 1'b1;
         MODE_BIAS:   bias_set[b.row] = 1'b1;
         MODE_SOURCE: source_set[b.col] = 1'b1;
         default: ;
      endcase
   endfunction

   // fill whatever the coming start would read before it was written
   function automatic void queue_start(input bit drain);
      for (int r = 0; r < gen_rows; r++) begin
         for (int c = 0; c < gen_cols; c++) begin
            if (!weight_set[r][c])
               queue_beat(MODE_WEIGHT, r, c, rand_q88(), $urandom, 1'b0);
         end
         if (!bias_set[r])
            queue_beat(MODE_BIAS, r, $urandom_range(0, 63), rand_q88(), rand_q1616(), 1'b0);
      end
      for (int c = 0; c < gen_cols; c++) begin
         if (!source_set[c])
            queue_beat(MODE_SOURCE, $urandom_range(0, 63), c, rand_q88(), $urandom, 1'b0);
      end
      queue_beat(MODE_START, $urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom),
                 $urandom, drain);
   endfunction

   function automatic void queue_random_load();
      mode_type mode;
      int       row;
      int       col;
      mode = mode_type'($urandom_range(0, 2));
      row = ($urandom_range(0, 9) < 7) ? $urandom_range(0, gen_rows - 1) : $urandom_range(0, 63);
      col = ($urandom_range(0, 9) < 7) ? $urandom_range(0, gen_cols - 1) : $urandom_range(0, 63);
      queue_beat(mode, row, col, rand_q88(), rand_q1616(), 1'b0);
   endfunction

   task automatic write_count(input logic idx, input logic [6:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ROW_COUNT) row_count_reg = data;
      else column_count_reg = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_counts(input int rows_raw, input int cols_raw);
      write_count(CSR_ROW_COUNT, rows_raw[6:0]);
      write_count(CSR_COLUMN_COUNT, cols_raw[6:0]);
      gen_rows = clip_count(rows_raw[6:0], MAX_ROWS);
      gen_cols = clip_count(cols_raw[6:0], COL_LIMIT);
   endtask

   task automatic wait_for_drain();
      do @(posedge clock);
      while (beat_pending.size() != 0 || req_valid || net_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sender: bursts of beats with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (beat_pending.size() > 0 &&
                      (!beat_pending[0].drain_first || net_expect.size() == 0)) begin
            beat_now = beat_pending.pop_front();
            req_valid <= 1'b1;
            req_mode <= beat_now.mode;
            req_row <= beat_now.row;
            req_col <= beat_now.col;
            req_value <= beat_now.value;
            req_bias_value <= beat_now.bias_value;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, drawn at random from four styles
   always @(negedge clock) begin
      if (cycle_count % 256 == 0) stall_style = $urandom_range(0, 3);
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((cycle_count % 16) < 10);
      endcase
   end

   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         absorb_beat(req_mode, req_row, req_col, req_value, req_bias_value);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (net_expect.size() == 0) begin
            $error("rsp beat with nothing expected: row_index %0d net_value %0d",
                   rsp_row_index, rsp_net_value);
            fail_count++;
         end else begin
            rsp_want = net_expect.pop_front();
            if (rsp_row_index !== rsp_want.row_index) begin
               $error("row_index mismatch: expected %0d, got %0d",
                      rsp_want.row_index, rsp_row_index);
               fail_count++;
            end
            if (rsp_net_value !== rsp_want.net_value) begin
               $error("net_value mismatch: expected %0d, got %0d",
                      rsp_want.net_value, rsp_net_value);
               fail_count++;
            end
            if (rsp_last !== rsp_want.last) begin
               $error("last mismatch: expected %0b, got %0b", rsp_want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_dense_layer_net_input_core: done, errors");
         $finish;
      end
   end

   initial begin
      int rows_pick;
      int cols_pick;
      int span;
      int phase_idx;
      int extreme_rows [4];
      int extreme_cols [4];
      extreme_rows = '{127, 0, 64, 1};
      extreme_cols = '{0, 127, 1, 64};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: saturation both ways, ignored fields, index extremes
      apply_counts(2, 2);
      queue_beat(MODE_SOURCE, 5, 0, 16'h8000, $urandom, 1'b0);
      queue_beat(MODE_SOURCE, 63, 1, 16'h8000, $urandom, 1'b0);
      queue_beat(MODE_WEIGHT, 0, 0, 16'h8000, $urandom, 1'b0);
      queue_beat(MODE_WEIGHT, 0, 1, 16'h8000, $urandom, 1'b0);
      queue_beat(MODE_WEIGHT, 1, 0, 16'h7FFF, $urandom, 1'b0);
      queue_beat(MODE_WEIGHT, 1, 1, 16'h7FFF, $urandom, 1'b0);
      queue_beat(MODE_BIAS, 0, 63, 16'($urandom), 32'h7FFF_FFFF, 1'b0);
      queue_beat(MODE_BIAS, 1, 0, 16'($urandom), 32'h8000_0000, 1'b0);
      queue_beat(MODE_START, 63, 63, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_beat(MODE_WEIGHT, 63, 63, 16'h7FFF, 32'h7FFF_FFFF, 1'b1);
      queue_beat(MODE_BIAS, 63, 63, 16'hFFFF, 32'h7FFF_FFFF, 1'b0);
      queue_beat(MODE_SOURCE, 63, 63, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_beat(MODE_WEIGHT, 0, 0, 16'h0100, 32'h0, 1'b0);
      queue_beat(MODE_WEIGHT, 0, 1, 16'hFF00, 32'h0, 1'b0);
      queue_beat(MODE_BIAS, 0, 0, 16'h0, 32'h0, 1'b0);
      queue_beat(MODE_BIAS, 1, 0, 16'h0, 32'hFFFF_FFFF, 1'b0);
      queue_beat(MODE_SOURCE, 0, 0, 16'h0000, 32'h0, 1'b0);
      queue_beat(MODE_START, 0, 0, 16'h0, 32'h0, 1'b0);
      wait_for_drain();

      // random phases, each under its own row and column counts
      phase_idx = 0;
      while (item_total < ITEM_TARGET) begin
         if (phase_idx < 4) begin
            rows_pick = extreme_rows[phase_idx];
            cols_pick = extreme_cols[phase_idx];
         end else if ($urandom_range(0, 7) == 0) begin
            rows_pick = $urandom_range(0, 1) ? 127 : 64;
            cols_pick = $urandom_range(0, 1);
         end else begin
            rows_pick = $urandom_range(0, 8);
            cols_pick = $urandom_range(0, 8);
         end
         apply_counts(rows_pick, cols_pick);
         span = $urandom_range(8, 40);
         repeat (span) begin
            if ($urandom_range(0, 6) == 0) queue_start($urandom_range(0, 5) == 0);
            else queue_random_load();
         end
         queue_start($urandom_range(0, 5) == 0);
         wait_for_drain();
         phase_idx++;
      end

      if (fail_count == 0) begin
         $display("tb_dense_layer_net_input_core: done, clean");
      end else begin
         $display("tb_dense_layer_net_input_core: done, errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/dlni_pkg.sv
rtl/dlni_dp.sv
rtl/dlni_ctrl.sv
rtl/dense_layer_net_input_core.sv
rtl/dlni_checker.sv
tb/sv/tb_dense_layer_net_input_core.sv
